// ----- sv/wacf_pkg.sv -----
`timescale 1ns / 1ps
package wacf_pkg;

    localparam int MAX_SAMPLES = 16384;
    localparam int CNT_W       = 15;
    localparam int CFG_IDX_W   = 8;
    localparam int DIV_CNT_W   = 7;
    localparam int DVD_W       = 128;

    localparam logic [CFG_IDX_W-1:0] REG_FORCED_EN  = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FORCED_AMP = 8'd1;

    localparam logic [63:0] SMAX    = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] SMIN    = 64'h8000_0000_0000_0000;
    localparam logic [31:0] AMP_ERR = 32'hFFFF_0000;
    localparam logic [31:0] AMP_MAX = 32'h7FFF_FFFF;

    // divider bit counts for the three divisions
    localparam logic [DIV_CNT_W-1:0] DIV_N_WEIGHT = 7'd33;
    localparam logic [DIV_CNT_W-1:0] DIV_N_AMP    = 7'd80;
    localparam logic [DIV_CNT_W-1:0] DIV_N_CHI    = 7'd78;

    typedef struct packed {
        logic signed [23:0] spectrum_flux;
        logic signed [23:0] template_flux;
        logic        [15:0] sigma;
        logic               use_sample;
        logic               last;
    } in_item_t;

    typedef struct packed {
        logic signed [63:0] chi_square;
        logic signed [31:0] amplitude;
        logic               fit_status;
        logic        [14:0] samples_used;
    } out_item_t;

    typedef enum logic [4:0] {
        OP_NOP,
        OP_LOAD,
        OP_WDIV,
        OP_DIV_STEP,
        OP_WMUL,
        OP_WACC,
        OP_AMP_DIV,
        OP_AMP_SET,
        OP_PMUL,
        OP_PACC,
        OP_PSAT,
        OP_FIT,
        OP_CMUL,
        OP_CACC,
        OP_CHI_DIV,
        OP_CHI_SET,
        OP_ERR_SET,
        OP_OUT
    } dp_op_t;

    typedef struct packed {
        dp_op_t     op;
        logic [1:0] part;
    } dp_cmd_t;

    typedef struct packed {
        logic div_last;
        logic use_s;
        logic last_s;
        logic data_err;
        logic amp_direct;
    } dp_status_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_LOADED,
        ST_WDIV_RUN,
        ST_WMUL,
        ST_WACC,
        ST_END,
        ST_AMP_RUN,
        ST_AMP_SET,
        ST_PMUL,
        ST_PACC,
        ST_PSAT,
        ST_FIT,
        ST_CMUL,
        ST_CACC,
        ST_CHI_DIV,
        ST_CHI_RUN,
        ST_CHI_SET,
        ST_OUT
    } ctrl_state_t;

    function automatic logic [63:0] sat_add64(input logic [63:0] a, input logic [63:0] b);
        logic [63:0] r;
        r = a + b;
        if (a[63] == b[63] && r[63] != a[63]) begin
            r = a[63] ? SMIN : SMAX;
        end
        return r;
    endfunction

    function automatic logic [63:0] sat_sub64(input logic [63:0] a, input logic [63:0] b);
        logic [63:0] r;
        r = a - b;
        if (a[63] != b[63] && r[63] != a[63]) begin
            r = a[63] ? SMIN : SMAX;
        end
        return r;
    endfunction

    // signed value from sign and magnitude, saturated to 64 bits
    function automatic logic [63:0] sat_signed(input logic neg, input logic [DVD_W-1:0] mag);
        logic [63:0] r;
        if (neg) begin
            r = (mag > {64'd0, SMIN}) ? SMIN : (64'd0 - mag[63:0]);
        end else begin
            r = (mag > {64'd0, SMAX}) ? SMAX : mag[63:0];
        end
        return r;
    endfunction

endpackage

// ----- sv/wacf_dp.sv -----
`timescale 1ns / 1ps
module wacf_dp import wacf_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  dp_cmd_t              cmd,
    output dp_status_t           status,
    input  in_item_t             s_item,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [31:0]          cfg_data,
    output out_item_t            m_item
);

    logic        forced_en_reg;
    logic [31:0] forced_amp_reg;

    logic [63:0] sum_cross_reg, sum_tsq_reg, sum_ssq_reg;
    logic [63:0] sum_cross_next, sum_tsq_next, sum_ssq_next;
    logic [CNT_W-1:0] cnt_all_reg, cnt_used_reg;
    logic use_reg, last_reg;

    logic [47:0] prod_st_reg, prod_tt_reg, prod_ss_reg;
    logic [31:0] sg2_reg;

    // divider: dividend register collects quotient bits at the bottom
    logic [DVD_W-1:0]     dvd_reg, dvd_next;
    logic [64:0]          rem_reg, rem_next;
    logic [63:0]          dsr_reg, dsr_next;
    logic [DIV_CNT_W-1:0] dcnt_reg, dcnt_next;
    logic [64:0]          rem_sh;
    logic                 ge;

    logic [47:0] wm_hi_reg;
    logic [64:0] wm_lo_reg;
    logic        wneg_reg;

    logic [31:0]      amp_reg, amp_next;
    logic             status_reg;
    logic [63:0]      prod_reg;
    logic [DVD_W-1:0] acc_reg;
    logic [63:0]      p_reg, fit_reg, chi_reg;
    out_item_t        out_reg;

    logic [47:0] prod_sel, prod_mag;
    logic [32:0] wgt;
    logic [63:0] wsum, wval;
    logic [63:0] cmag, fmag;
    logic [31:0] amag;
    logic [31:0] mul_a, mul_b;
    logic [79:0] pshift;
    logic [15:0] sg;
    logic [31:0] fit_q;

    assign sg   = (s_item.sigma == 16'd0) ? 16'd1 : s_item.sigma;
    assign wgt  = dvd_reg[32:0];
    assign cmag = sum_cross_reg[63] ? (64'd0 - sum_cross_reg) : sum_cross_reg;
    assign fmag = fit_reg[63] ? (64'd0 - fit_reg) : fit_reg;
    assign amag = amp_reg[31] ? (32'd0 - amp_reg) : amp_reg;
    assign pshift = acc_reg[95:16];

    always_comb begin
        case (cmd.part)
            2'd0:    prod_sel = prod_st_reg;
            2'd1:    prod_sel = prod_tt_reg;
            default: prod_sel = prod_ss_reg;
        endcase
        prod_mag = prod_sel[47] ? (48'd0 - prod_sel) : prod_sel;
    end

    always_comb begin
        wsum = 64'(wm_hi_reg) + 64'(wm_lo_reg[64:32]);
        wval = wneg_reg ? (64'd0 - wsum) : wsum;
        sum_cross_next = sum_cross_reg;
        sum_tsq_next   = sum_tsq_reg;
        sum_ssq_next   = sum_ssq_reg;
        case (cmd.part)
            2'd0:    sum_cross_next = sat_add64(sum_cross_reg, wval);
            2'd1:    sum_tsq_next   = sat_add64(sum_tsq_reg, wval);
            default: sum_ssq_next   = sat_add64(sum_ssq_reg, wval);
        endcase
    end

    always_comb begin
        if (cmd.op == OP_CMUL) begin
            mul_a = cmd.part[0] ? fmag[63:32] : fmag[31:0];
            mul_b = {{(32-CNT_W){1'b0}}, cnt_all_reg};
        end else begin
            mul_a = cmd.part[0] ? cmag[63:32] : cmag[31:0];
            mul_b = amag;
        end
    end

    always_comb begin
        rem_sh    = {rem_reg[63:0], dvd_reg[DVD_W-1]};
        ge        = rem_sh >= {1'b0, dsr_reg};
        dvd_next  = dvd_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        dcnt_next = dcnt_reg;
        unique case (cmd.op)
            OP_WDIV: begin
                dvd_next  = {1'b1, {(DVD_W-1){1'b0}}};
                rem_next  = '0;
                dsr_next  = {32'd0, sg2_reg};
                dcnt_next = DIV_N_WEIGHT;
            end
            OP_AMP_DIV: begin
                dvd_next  = {sum_cross_reg, 64'd0};
                rem_next  = '0;
                dsr_next  = sum_tsq_reg;
                dcnt_next = DIV_N_AMP;
            end
            OP_CHI_DIV: begin
                dvd_next  = {acc_reg[77:0], 50'd0};
                rem_next  = '0;
                dsr_next  = {{(64-CNT_W){1'b0}}, cnt_used_reg};
                dcnt_next = DIV_N_CHI;
            end
            OP_DIV_STEP: begin
                dvd_next  = {dvd_reg[DVD_W-2:0], ge};
                rem_next  = ge ? (rem_sh - {1'b0, dsr_reg}) : rem_sh;
                dcnt_next = dcnt_reg - 1'b1;
            end
            default: ;
        endcase
    end

    always_comb begin
        fit_q = (dvd_reg >= 128'h8000_0000) ? AMP_MAX : dvd_reg[31:0];
        if (forced_en_reg) begin
            amp_next = forced_amp_reg;
        end else if (sum_cross_reg[63] || sum_tsq_reg[63]) begin
            amp_next = 32'd0;
        end else begin
            amp_next = fit_q;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            forced_en_reg  <= 1'b0;
            forced_amp_reg <= '0;
        end else if (cfg_we) begin
            unique case (cfg_index)
                REG_FORCED_EN:  forced_en_reg  <= cfg_data[0];
                REG_FORCED_AMP: forced_amp_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sum_cross_reg <= '0;
            sum_tsq_reg   <= '0;
            sum_ssq_reg   <= '0;
            cnt_all_reg   <= '0;
            cnt_used_reg  <= '0;
        end else begin
            unique case (cmd.op)
                OP_LOAD: begin
                    if (cnt_all_reg < CNT_W'(MAX_SAMPLES)) begin
                        cnt_all_reg <= cnt_all_reg + 1'b1;
                    end
                    if (s_item.use_sample && cnt_used_reg < CNT_W'(MAX_SAMPLES)) begin
                        cnt_used_reg <= cnt_used_reg + 1'b1;
                    end
                end
                OP_WACC: begin
                    sum_cross_reg <= sum_cross_next;
                    sum_tsq_reg   <= sum_tsq_next;
                    sum_ssq_reg   <= sum_ssq_next;
                end
                OP_OUT: begin
                    sum_cross_reg <= '0;
                    sum_tsq_reg   <= '0;
                    sum_ssq_reg   <= '0;
                    cnt_all_reg   <= '0;
                    cnt_used_reg  <= '0;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        dvd_reg  <= dvd_next;
        rem_reg  <= rem_next;
        dsr_reg  <= dsr_next;
        dcnt_reg <= dcnt_next;
        unique case (cmd.op)
            OP_LOAD: begin
                use_reg     <= s_item.use_sample;
                last_reg    <= s_item.last;
                sg2_reg     <= sg * sg;
                prod_st_reg <= 48'(s_item.spectrum_flux * s_item.template_flux);
                prod_tt_reg <= 48'(s_item.template_flux * s_item.template_flux);
                prod_ss_reg <= 48'(s_item.spectrum_flux * s_item.spectrum_flux);
            end
            OP_WMUL: begin
                wm_hi_reg <= 48'(prod_mag[46:32] * wgt);
                wm_lo_reg <= 65'(prod_mag[31:0] * wgt);
                wneg_reg  <= prod_sel[47];
            end
            OP_AMP_SET: begin
                amp_reg    <= amp_next;
                status_reg <= 1'b0;
                acc_reg    <= '0;
            end
            OP_PMUL, OP_CMUL: prod_reg <= mul_a * mul_b;
            OP_PACC, OP_CACC: begin
                if (cmd.part[0]) begin
                    acc_reg <= acc_reg + {32'd0, prod_reg, 32'd0};
                end else begin
                    acc_reg <= acc_reg + {64'd0, prod_reg};
                end
            end
            OP_PSAT: p_reg <= sat_signed(sum_cross_reg[63] ^ amp_reg[31], {48'd0, pshift});
            OP_FIT: begin
                fit_reg <= sat_sub64(sum_ssq_reg, p_reg);
                acc_reg <= '0;
            end
            OP_CHI_SET: chi_reg <= sat_signed(fit_reg[63], dvd_reg);
            OP_ERR_SET: begin
                chi_reg    <= SMAX;
                amp_reg    <= AMP_ERR;
                status_reg <= 1'b1;
            end
            OP_OUT: begin
                out_reg.chi_square   <= chi_reg;
                out_reg.amplitude    <= amp_reg;
                out_reg.fit_status   <= status_reg;
                out_reg.samples_used <= cnt_used_reg;
            end
            default: ;
        endcase
    end

    assign status.div_last   = (dcnt_reg == DIV_CNT_W'(1));
    assign status.use_s      = use_reg;
    assign status.last_s     = last_reg;
    assign status.data_err   = (cnt_used_reg == '0) || (sum_cross_reg == '0)
                               || (sum_tsq_reg == '0);
    assign status.amp_direct = forced_en_reg || sum_cross_reg[63] || sum_tsq_reg[63];
    assign m_item = out_reg;

endmodule

// ----- sv/wacf_ctrl.sv -----
`timescale 1ns / 1ps
module wacf_ctrl import wacf_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    output logic       m_valid,
    input  logic       m_ready,
    input  dp_status_t status,
    output dp_cmd_t    cmd
);

    ctrl_state_t state_reg, state_next;
    logic [1:0]  part_reg, part_next;
    logic        m_valid_reg, m_valid_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            part_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            part_reg    <= part_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        part_next  = part_reg;
        cmd.op     = OP_NOP;
        cmd.part   = part_reg;
        s_ready    = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.op     = OP_LOAD;
                    state_next = ST_LOADED;
                end
            end
            ST_LOADED: begin
                part_next = '0;
                if (status.use_s) begin
                    cmd.op     = OP_WDIV;
                    state_next = ST_WDIV_RUN;
                end else if (status.last_s) begin
                    state_next = ST_END;
                end else begin
                    state_next = ST_IDLE;
                end
            end
            ST_WDIV_RUN: begin
                cmd.op = OP_DIV_STEP;
                if (status.div_last) state_next = ST_WMUL;
            end
            ST_WMUL: begin
                cmd.op     = OP_WMUL;
                state_next = ST_WACC;
            end
            ST_WACC: begin
                cmd.op = OP_WACC;
                if (part_reg == 2'd2) begin
                    part_next  = '0;
                    state_next = status.last_s ? ST_END : ST_IDLE;
                end else begin
                    part_next  = part_reg + 1'b1;
                    state_next = ST_WMUL;
                end
            end
            ST_END: begin
                part_next = '0;
                if (status.data_err) begin
                    cmd.op     = OP_ERR_SET;
                    state_next = ST_OUT;
                end else if (status.amp_direct) begin
                    cmd.op     = OP_AMP_SET;
                    state_next = ST_PMUL;
                end else begin
                    cmd.op     = OP_AMP_DIV;
                    state_next = ST_AMP_RUN;
                end
            end
            ST_AMP_RUN: begin
                cmd.op = OP_DIV_STEP;
                if (status.div_last) state_next = ST_AMP_SET;
            end
            ST_AMP_SET: begin
                cmd.op     = OP_AMP_SET;
                state_next = ST_PMUL;
            end
            ST_PMUL: begin
                cmd.op     = OP_PMUL;
                state_next = ST_PACC;
            end
            ST_PACC: begin
                cmd.op = OP_PACC;
                if (part_reg[0]) begin
                    part_next  = '0;
                    state_next = ST_PSAT;
                end else begin
                    part_next  = 2'd1;
                    state_next = ST_PMUL;
                end
            end
            ST_PSAT: begin
                cmd.op     = OP_PSAT;
                state_next = ST_FIT;
            end
            ST_FIT: begin
                cmd.op     = OP_FIT;
                state_next = ST_CMUL;
            end
            ST_CMUL: begin
                cmd.op     = OP_CMUL;
                state_next = ST_CACC;
            end
            ST_CACC: begin
                cmd.op = OP_CACC;
                if (part_reg[0]) begin
                    part_next  = '0;
                    state_next = ST_CHI_DIV;
                end else begin
                    part_next  = 2'd1;
                    state_next = ST_CMUL;
                end
            end
            ST_CHI_DIV: begin
                cmd.op     = OP_CHI_DIV;
                state_next = ST_CHI_RUN;
            end
            ST_CHI_RUN: begin
                cmd.op = OP_DIV_STEP;
                if (status.div_last) state_next = ST_CHI_SET;
            end
            ST_CHI_SET: begin
                cmd.op     = OP_CHI_SET;
                state_next = ST_OUT;
            end
            ST_OUT: begin
                // wait until the output register is free
                if (!m_valid_reg || m_ready) begin
                    cmd.op     = OP_OUT;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    assign m_valid_next = (m_valid_reg && !m_ready) || (cmd.op == OP_OUT);
    assign m_valid      = m_valid_reg;

endmodule

// ----- sv/weighted_amplitude_chi_square_fit_top.sv -----
`timescale 1ns / 1ps
// Channel   Ports                                  Carries
// input     s_valid, s_ready, s_item               one sample request
// result    m_valid, m_ready, m_item               one fit result per spectrum
// config    cfg_valid, cfg_ready, cfg_index/data   register write
//
// A masked sample only loads and counts; a used sample also runs the
// 1-bit-per-cycle divider forming the weight 2^32/sigma^2 (33 steps).
// The last sample adds an 80-step amplitude division and
// a 78-step chi-square division on the same divider, plus multiply steps;
// a forced or zero amplitude skips the first division.
// Reset is synchronous and clears sums, counts, registers and control.
// A waiting result does not stop sample intake; only the final write of the
// next result waits for the output register to drain.
module weighted_amplitude_chi_square_fit_top import wacf_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  in_item_t             s_item,
    output logic                 m_valid,
    input  logic                 m_ready,
    output out_item_t            m_item,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [31:0]          cfg_data
);

    dp_cmd_t    cmd;
    dp_status_t status;

    assign cfg_ready = 1'b1;

    wacf_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .status  (status),
        .cmd     (cmd)
    );

    wacf_dp u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .status    (status),
        .s_item    (s_item),
        .cfg_we    (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .m_item    (m_item)
    );

endmodule
